// ----- hdl/pms_pkg.sv -----
// Package for the partitioned multi-stack: sizes, field codes, payload and
// command structs. No dependencies; every file but pms_ram takes names from here.
`default_nettype none

package pms_pkg;

    localparam int SLICE_DEPTH = 128;
    localparam int MAX_STACKS  = 3;

    localparam int DATA_W  = 32;
    localparam int CFG_W   = 2;
    localparam int STK_W   = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
    localparam int CNT_W   = $clog2(SLICE_DEPTH + 1);
    localparam int MEM_DEPTH = MAX_STACKS * SLICE_DEPTH;
    localparam int ADDR_W  = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [CFG_W-1:0] CFG_RESET = 2'd3;

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_PEEK = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic [1:0]               operation;
        logic [1:0]               stack_index;
        logic signed [DATA_W-1:0] push_value;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [1:0]               status;
        logic                     is_full;
        logic                     is_empty;
    } t_out;

    // classified operation handed from front to back
    typedef struct packed {
        logic              wr;
        logic              rd;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic [1:0]        status;
        logic              is_full;
        logic              is_empty;
    } t_cmd;

endpackage

`default_nettype wire

// ----- hdl/pms_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`default_nettype none

module pms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 384
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]              i_wdata,
    input  wire logic                          i_re,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic      [WIDTH-1:0]              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hdl/pms_front.sv -----
// Front end: holds the config register and the per-stack fill counts,
// classifies each beat and emits a memory command. Uses pms_pkg.
`default_nettype none

module pms_front (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [pms_pkg::CFG_W-1:0] i_cfg_wdata,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire pms_pkg::t_in            i_item,
    output logic                         o_cmd_valid,
    input  wire logic                    i_cmd_ready,
    output pms_pkg::t_cmd                o_cmd
);

    logic [pms_pkg::CFG_W-1:0] r_stacks_in_use;
    logic [pms_pkg::CNT_W-1:0] r_cnt [pms_pkg::MAX_STACKS];

    logic [31:0]               w_limit;
    logic                      w_idx_ok;
    logic [pms_pkg::STK_W-1:0] w_sel;
    logic [pms_pkg::CNT_W-1:0] w_cnt;
    logic [pms_pkg::CNT_W-1:0] n_cnt;
    logic [31:0]               w_base;
    logic [31:0]               w_addr;
    logic                      w_acc;

    always_comb begin
        w_limit = (32'(r_stacks_in_use) > 32'(pms_pkg::MAX_STACKS))
                ? 32'(pms_pkg::MAX_STACKS) : 32'(r_stacks_in_use);
        w_idx_ok = 32'(i_item.stack_index) < w_limit;
        w_sel    = w_idx_ok ? pms_pkg::STK_W'(i_item.stack_index) : '0;
        w_cnt    = r_cnt[w_sel];
        w_base   = 32'(w_sel) * 32'(pms_pkg::SLICE_DEPTH);
        w_addr   = w_base;
        n_cnt    = w_cnt;

        o_cmd        = '0;
        o_cmd.data   = i_item.push_value;
        o_cmd.status = pms_pkg::ST_OK;

        if (!w_idx_ok) begin
            o_cmd.status = pms_pkg::ST_RANGE;
        end else begin
            case (i_item.operation)
                pms_pkg::OP_PUSH: begin
                    if (32'(w_cnt) >= 32'(pms_pkg::SLICE_DEPTH)) begin
                        o_cmd.status = pms_pkg::ST_FULL;
                    end else begin
                        o_cmd.wr = 1'b1;
                        w_addr   = w_base + 32'(w_cnt);
                        n_cnt    = w_cnt + 1'b1;
                    end
                end
                pms_pkg::OP_POP, pms_pkg::OP_PEEK: begin
                    if (w_cnt == '0) begin
                        o_cmd.status = pms_pkg::ST_EMPTY;
                    end else begin
                        o_cmd.rd = 1'b1;
                        w_addr   = w_base + 32'(w_cnt) - 32'd1;
                        if (i_item.operation == pms_pkg::OP_POP) begin
                            n_cnt = w_cnt - 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        o_cmd.addr     = w_addr[pms_pkg::ADDR_W-1:0];
        o_cmd.is_full  = w_idx_ok && (32'(n_cnt) >= 32'(pms_pkg::SLICE_DEPTH));
        o_cmd.is_empty = w_idx_ok && (n_cnt == '0);
    end

    assign o_cmd_valid = i_valid;
    assign o_ready     = i_cmd_ready;
    assign w_acc       = i_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stacks_in_use <= pms_pkg::CFG_RESET;
            for (int s = 0; s < pms_pkg::MAX_STACKS; s++) begin
                r_cnt[s] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_stacks_in_use <= i_cfg_wdata;
            end
            if (w_acc && w_idx_ok) begin
                r_cnt[w_sel] <= n_cnt;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/pms_fifo.sv -----
// Two-entry command queue between front and back ends.
// Uses pms_pkg for the command type and queue sizing.
`default_nettype none

module pms_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire pms_pkg::t_cmd i_cmd,
    output logic               o_valid,
    input  wire logic          i_ready,
    output pms_pkg::t_cmd      o_cmd
);

    pms_pkg::t_cmd              r_mem [pms_pkg::QUEUE_DEPTH];
    logic [pms_pkg::QPTR_W-1:0] r_wptr;
    logic [pms_pkg::QPTR_W-1:0] r_rptr;
    logic [pms_pkg::QCNT_W-1:0] r_count;
    logic                       w_push;
    logic                       w_pop;

    assign o_ready = r_count != pms_pkg::QCNT_W'(pms_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hdl/pms_back.sv -----
// Back end: issues each command to the stack RAM, holds it in stage s1 while
// the registered read data arrives, then holds the result in an output register. Uses pms_pkg, pms_ram.
`default_nettype none

module pms_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cmd_valid,
    output logic               o_cmd_ready,
    input  wire pms_pkg::t_cmd i_cmd,
    output logic               o_valid,
    input  wire logic          i_ready,
    output pms_pkg::t_out      o_res
);

    logic                       r_s1_valid;
    pms_pkg::t_cmd              r_s1_cmd;
    logic                       r_out_valid;
    pms_pkg::t_out              r_out;
    logic [pms_pkg::DATA_W-1:0] w_rdata;
    logic                       w_adv;
    logic                       w_issue;
    pms_pkg::t_out              n_out;

    // s1 moves on when the output register is free or being drained
    assign w_adv       = r_s1_valid && (!r_out_valid || i_ready);
    assign o_cmd_ready = !r_s1_valid || w_adv;
    assign w_issue     = i_cmd_valid && o_cmd_ready;

    pms_ram #(
        .WIDTH (pms_pkg::DATA_W),
        .DEPTH (pms_pkg::MEM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_issue && i_cmd.wr),
        .i_waddr (i_cmd.addr),
        .i_wdata (i_cmd.data),
        .i_re    (w_issue && i_cmd.rd),
        .i_raddr (i_cmd.addr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_out.read_value = r_s1_cmd.rd ? w_rdata : '0;
        n_out.status     = r_s1_cmd.status;
        n_out.is_full    = r_s1_cmd.is_full;
        n_out.is_empty   = r_s1_cmd.is_empty;
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_s1_cmd <= i_cmd;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_issue) begin
                r_s1_valid <= 1'b1;
            end else if (w_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule

`default_nettype wire

// ----- hdl/partitioned_multi_stack_core.sv -----
// Partitioned multi-stack: up to MAX_STACKS LIFO stacks, each owning a fixed
// slice of SLICE_DEPTH words in one shared RAM. Sustained rate is one beat
// per cycle in and out while the result side is ready; each accepted beat
// passes through the command queue, the RAM read stage s1 and then the
// output register. Fill counts clear on reset; the storage is not cleared
// and needs no sweep, since a word is only read after it was pushed. The
// user writes stacks_in_use only while idle; the block does not enforce it.
// Depends on pms_pkg, pms_front, pms_fifo, pms_back, pms_ram.
`default_nettype none

module partitioned_multi_stack_core (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [pms_pkg::CFG_W-1:0] i_cfg_wdata,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire pms_pkg::t_in              i_in,
    output logic                           o_res_valid,
    input  wire logic                      i_res_ready,
    output pms_pkg::t_out                  o_res
);

    logic          w_f_valid;
    logic          w_f_ready;
    pms_pkg::t_cmd w_f_cmd;
    logic          w_q_valid;
    logic          w_q_ready;
    pms_pkg::t_cmd w_q_cmd;

    pms_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_item      (i_in),
        .o_cmd_valid (w_f_valid),
        .i_cmd_ready (w_f_ready),
        .o_cmd       (w_f_cmd)
    );

    pms_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_cmd   (w_f_cmd),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_cmd   (w_q_cmd)
    );

    pms_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .o_cmd_ready (w_q_ready),
        .i_cmd       (w_q_cmd),
        .o_valid     (o_res_valid),
        .i_ready     (i_res_ready),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

// ----- hdl/pms_checker.sv -----
// Port-level checks for partitioned_multi_stack_core, bound to the top level.
// Uses pms_pkg for status codes.
`default_nettype none

module pms_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      o_res_valid,
    input wire logic                      i_res_ready,
    input wire pms_pkg::t_out             o_res
);

    // nothing comes out in the cycle after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result beat right after reset");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !i_res_ready) |=> (o_res_valid && $stable(o_res)))
        else $error("stalled result beat changed");

    a_range_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status == pms_pkg::ST_RANGE) |->
        (o_res.read_value == '0 && !o_res.is_full && !o_res.is_empty))
        else $error("range error beat carries data or flags");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !(o_res.is_full && o_res.is_empty))
        else $error("stack both full and empty");

    a_err_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.status == pms_pkg::ST_FULL ||
                         o_res.status == pms_pkg::ST_EMPTY)) |->
        (o_res.read_value == '0 &&
         (o_res.status == pms_pkg::ST_FULL ? o_res.is_full : o_res.is_empty)))
        else $error("failed operation flags or data wrong");

endmodule

bind partitioned_multi_stack_core pms_checker u_pms_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_res_valid (o_res_valid),
    .i_res_ready (i_res_ready),
    .o_res       (o_res)
);

`default_nettype wire
